FILE: rtl/battery_level_gauge_macros.svh
// Assertion macros shared by the battery gauge checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef BATTERY_LEVEL_GAUGE_MACROS_SVH
`define BATTERY_LEVEL_GAUGE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BLG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BLG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/blg_pkg.sv
// Shared types, constants and the level band function of the battery gauge.
// No dependencies; imported by the interfaces, blg_decide and the top level.
package blg_pkg;

  // Field widths
  localparam int unsigned CONV_HI_W   = 8;
  localparam int unsigned CONV_LO_W   = 4;
  localparam int unsigned READING_W   = 12;
  localparam int unsigned LEVEL_W     = 3;
  localparam int unsigned CONFIRM_W   = 8;
  localparam int unsigned HSUM_W      = 11;
  localparam int unsigned LSUM_W      = 7;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned FRUN_W      = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOW_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HIGH_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOW_CONFIRM = 2'd2;

  // Configuration reset values
  localparam logic [READING_W-1:0] LOW_LIMIT_RST   = 12'd1110;
  localparam logic [READING_W-1:0] HIGH_LIMIT_RST  = 12'd1550;
  localparam logic [CONFIRM_W-1:0] LOW_CONFIRM_RST = 8'd10;

  // Sequencing and saturation constants
  localparam logic [IDX_W-1:0]     LAST_SAMPLE   = 3'd7;
  localparam logic [CONFIRM_W-1:0] LOW_RUN_MAX   = 8'd255;
  localparam logic [FRUN_W-1:0]    FLASH_AT      = 4'd10;
  localparam logic [FRUN_W-1:0]    FLASH_RUN_MAX = 4'd11;
  localparam logic [LEVEL_W-1:0]   LEVEL_MAX     = 3'd5;

  // Hysteresis band edges, reading above the floor
  localparam logic [READING_W-1:0] R_FULL     = 12'd440;
  localparam logic [READING_W-1:0] R_B4_LO    = 12'd355;
  localparam logic [READING_W-1:0] R_B4_HOLD  = 12'd400;
  localparam logic [READING_W-1:0] R_B3_LO    = 12'd200;
  localparam logic [READING_W-1:0] R_B3_HOLD  = 12'd260;
  localparam logic [READING_W-1:0] R_B2_LO    = 12'd100;
  localparam logic [READING_W-1:0] R_B2_HOLD  = 12'd190;
  localparam logic [READING_W-1:0] R_B1_HOLD  = 12'd90;

  typedef struct packed {
    logic [READING_W-1:0] low_limit;
    logic [READING_W-1:0] high_limit;
    logic [CONFIRM_W-1:0] low_confirm;
  } blg_cfg_t;

  // Tracking state carried from one average to the next
  typedef struct packed {
    logic [LEVEL_W-1:0]   level;
    logic [CONFIRM_W-1:0] low_run;
    logic [FRUN_W-1:0]    flash_run;
  } blg_trk_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]   battery_level;
    logic                 flash_request;
    logic [READING_W-1:0] level_reading;
  } blg_res_t;

  // Move the gauge step through the hysteresis bands
  function automatic logic [LEVEL_W-1:0] next_level(input logic [LEVEL_W-1:0] cur,
                                                    input logic [READING_W-1:0] r);
    logic [LEVEL_W-1:0] lv;
    lv = cur;
    if (r >= R_FULL) begin
      lv = 3'd5;
    end else if (r > R_B4_LO) begin
      if (cur < 3'd4 || r < R_B4_HOLD) lv = 3'd4;
    end else if (r > R_B3_LO) begin
      if (cur <= 3'd3 || r < R_B3_HOLD) lv = 3'd3;
    end else if (r > R_B2_LO) begin
      if (cur <= 3'd2 || r < R_B2_HOLD) lv = 3'd2;
    end else if (r != '0) begin
      if (cur <= 3'd1 || r < R_B1_HOLD) lv = 3'd1;
    end
    return lv;
  endfunction

endpackage

FILE: rtl/blg_chan_if.sv
// Valid/ready channel interfaces for conversion beats and gauge result beats.
// Depends on blg_pkg for field widths.
interface blg_in_if import blg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CONV_HI_W-1:0] conv_high;
  logic [CONV_LO_W-1:0] conv_low;
  logic                 motor_running;

  modport source (output valid, conv_high, conv_low, motor_running, input ready);
  modport sink   (input valid, conv_high, conv_low, motor_running, output ready);
endinterface

interface blg_out_if import blg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [LEVEL_W-1:0]   battery_level;
  logic                 flash_request;
  logic [READING_W-1:0] level_reading;

  modport source (output valid, battery_level, flash_request, level_reading, input ready);
  modport sink   (input valid, battery_level, flash_request, level_reading, output ready);
endinterface

FILE: rtl/blg_decide.sv
// Low-battery confirmation, flash counting and level band update for one average.
// Depends on blg_pkg; instantiated by battery_level_gauge.
module blg_decide import blg_pkg::*; (
  input  logic [READING_W-1:0] avg,
  input  logic                 motor,
  input  blg_cfg_t             cfg,
  input  blg_trk_t             trk,
  output blg_trk_t             trk_nxt,
  output blg_res_t             res
);

  logic                 above;
  logic                 below;
  logic [CONFIRM_W-1:0] run_inc;
  logic [CONFIRM_W-1:0] need;
  logic [FRUN_W-1:0]    frun_inc;
  logic [READING_W-1:0] reading;

  // Compare against the limits and prepare saturating counts
  always_comb begin
    above    = avg > cfg.high_limit;
    below    = avg < cfg.low_limit;
    run_inc  = (trk.low_run == LOW_RUN_MAX) ? trk.low_run : trk.low_run + 8'd1;
    need     = (cfg.low_confirm == '0) ? 8'd1 : cfg.low_confirm;
    frun_inc = trk.flash_run + 4'd1;
  end

  // Pick the branch and form the result beat
  always_comb begin
    trk_nxt = trk;
    res     = '0;
    reading = '0;
    priority if (above) begin
      trk_nxt.low_run = '0;
      reading = below ? '0 : avg - cfg.low_limit;
      trk_nxt.level = next_level(trk.level, reading);
      res.battery_level = trk_nxt.level;
      res.level_reading = reading;
    end else if (below) begin
      if (run_inc < need) begin
        // still unconfirmed: report the raw average, hold the level
        trk_nxt.low_run = run_inc;
        res.battery_level = trk.level;
        res.level_reading = avg;
      end else begin
        // confirmed empty
        trk_nxt.low_run = cfg.low_confirm;
        trk_nxt.level = '0;
        if (motor) begin
          res.flash_request = (frun_inc == FLASH_AT);
          trk_nxt.flash_run = (frun_inc > FLASH_RUN_MAX) ? FLASH_RUN_MAX : frun_inc;
        end
        res.battery_level = '0;
        res.level_reading = '0;
      end
    end else begin
      trk_nxt.low_run   = '0;
      trk_nxt.flash_run = '0;
      reading = avg - cfg.low_limit;
      trk_nxt.level = next_level(trk.level, reading);
      res.battery_level = trk_nxt.level;
      res.level_reading = reading;
    end
  end

endmodule

FILE: rtl/battery_level_gauge.sv
// Top level of the battery gauge: input stage, eight-beat accumulator, result register.
// Depends on blg_pkg, blg_in_if/blg_out_if and blg_decide.
//
//  channel | direction | beat contents                              | handshake
//  in_ch   | in        | conv_high, conv_low, motor_running          | valid/ready
//  out_ch  | out       | battery_level, flash_request, level_reading | valid/ready
//  cfg_*   | in        | cfg_index, cfg_data                         | cfg_we only
//
// One conversion beat is accepted per cycle while the result register is free or
// draining; a result beat leaves after every eighth conversion is accepted.
// Latency is set by the input register and the result register; the averaging
// and band logic sits between them.
// rst_n (synchronous) clears the accumulator and tracking state and restores the limits to their reset values.
// A stalled result holds the pipe; the input stage still fills one beat.
module battery_level_gauge import blg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  blg_in_if.sink                in_ch,
  blg_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  blg_cfg_t             cfg_r;
  logic                 s1_valid_r;
  logic [CONV_HI_W-1:0] s1_high_r;
  logic [CONV_LO_W-1:0] s1_low_r;
  logic                 s1_motor_r;
  logic [IDX_W-1:0]     sample_index_r;
  logic [HSUM_W-1:0]    high_sum_r;
  logic [LSUM_W-1:0]    low_sum_r;
  blg_trk_t             trk_r;
  logic                 out_valid_r;
  blg_res_t             res_r;

  logic                 in_rdy;
  logic                 s1_adv;
  logic                 fire;
  logic                 last;
  logic [HSUM_W-1:0]    high_sum_nxt;
  logic [LSUM_W-1:0]    low_sum_nxt;
  logic [READING_W-1:0] avg;
  blg_trk_t             trk_nxt;
  blg_res_t             res_nxt;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_limit   <= LOW_LIMIT_RST;
      cfg_r.high_limit  <= HIGH_LIMIT_RST;
      cfg_r.low_confirm <= LOW_CONFIRM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_LOW_LIMIT:   cfg_r.low_limit   <= cfg_data;
        CFG_IDX_HIGH_LIMIT:  cfg_r.high_limit  <= cfg_data;
        CFG_IDX_LOW_CONFIRM: cfg_r.low_confirm <= cfg_data[CONFIRM_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: advance when the result register is free or draining
  always_comb begin
    s1_adv = !out_valid_r || out_ch.ready;
    in_rdy = !s1_valid_r || s1_adv;
    fire   = s1_valid_r && s1_adv;
    last   = (sample_index_r == LAST_SAMPLE);
  end
  assign in_ch.ready = in_rdy;

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_rdy) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      s1_high_r  <= in_ch.conv_high;
      s1_low_r   <= in_ch.conv_low;
      s1_motor_r <= in_ch.motor_running;
    end
  end

  // Accumulate and form the average on the eighth beat
  always_comb begin
    high_sum_nxt = high_sum_r + HSUM_W'(s1_high_r);
    low_sum_nxt  = low_sum_r + LSUM_W'(s1_low_r);
    avg          = {high_sum_nxt, 1'b0} + {8'd0, low_sum_nxt[LSUM_W-1:4], 1'b0};
  end

  blg_decide u_decide (
    .avg     (avg),
    .motor   (s1_motor_r),
    .cfg     (cfg_r),
    .trk     (trk_r),
    .trk_nxt (trk_nxt),
    .res     (res_nxt)
  );

  // Accumulator and tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_index_r <= '0;
      high_sum_r     <= '0;
      low_sum_r      <= '0;
      trk_r          <= '0;
    end else if (fire) begin
      if (last) begin
        sample_index_r <= '0;
        high_sum_r     <= '0;
        low_sum_r      <= '0;
        trk_r          <= trk_nxt;
      end else begin
        sample_index_r <= sample_index_r + 3'd1;
        high_sum_r     <= high_sum_nxt;
        low_sum_r      <= low_sum_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= fire && last;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && last) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.battery_level = res_r.battery_level;
  assign out_ch.flash_request = res_r.flash_request;
  assign out_ch.level_reading = res_r.level_reading;

endmodule

FILE: rtl/blg_checker.sv
// Port-level checks for battery_level_gauge, attached by the bind at the end.
// Depends on blg_pkg and battery_level_gauge_macros.svh.
`include "battery_level_gauge_macros.svh"

module blg_checker import blg_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [LEVEL_W-1:0]   battery_level,
  input logic                 flash_request,
  input logic [READING_W-1:0] level_reading
);

  // A stalled result beat stays put
  `BLG_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(level_reading) && $stable(battery_level), "stalled result beat changed")

  // Gauge step never exceeds full
  `BLG_ASSERT_IMP(a_level_max, clk, rst_n, out_valid, battery_level <= LEVEL_MAX, "battery level out of range")

  // A flash only comes with a confirmed empty battery
  `BLG_ASSERT_IMP(a_flash_empty, clk, rst_n, out_valid && flash_request, battery_level == '0 && level_reading == '0, "flash without confirmed empty")

  // Input is only throttled by a blocked result beat
  `BLG_ASSERT_IMP(a_ready_cause, clk, rst_n, !in_ready, out_valid && !out_ready, "input stalled without output backpressure")

endmodule

bind battery_level_gauge blg_checker u_blg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .battery_level (out_ch.battery_level),
  .flash_request (out_ch.flash_request),
  .level_reading (out_ch.level_reading)
);
